// ===== hw/rtl/pctd_pkg.sv =====
// Shared types and constants for the trial-division prime counter.
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int DIV_W       = VALUE_WIDTH / 2 + 2;
    localparam int SQ_W        = VALUE_WIDTH + 2;
    localparam int BIT_W       = $clog2(VALUE_WIDTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FIRST_DIV   = 5;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [2:0] {
        KIND_RESTART,
        KIND_DONE,
        KIND_COMPOSITE,
        KIND_PRIME,
        KIND_TRIAL
    } kind_t;

    typedef struct packed {
        kind_t  kind;
        value_t cand;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qport_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/pctd_if.sv =====
// Channel interfaces: input items, results and the limit register write port.
`timescale 1ns / 1ps

interface pctd_item_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface pctd_result_if
    import pctd_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t candidate;
    logic   prime_flag;
    value_t prime_total;
    logic   done_res;

    modport source (output valid, output candidate, output prime_flag,
                    output prime_total, output done_res, input ready);
    modport sink (input valid, input candidate, input prime_flag,
                  input prime_total, input done_res, output ready);
endinterface

interface pctd_cfg_if
    import pctd_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t limit;

    modport source (output valid, output limit, input ready);
    modport sink (input valid, input limit, output ready);
endinterface

// ===== hw/rtl/pctd_front.sv =====
// Front end: accepts items, advances the candidate and classifies it.
`timescale 1ns / 1ps

module pctd_front
    import pctd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    pctd_item_if.sink       item,
    pctd_cfg_if.sink        cfg,
    input  logic            q_full,
    output qport_t          push
);

    value_t     limit_reg;
    value_t     limit_next;
    value_t     next_cand_reg;
    value_t     next_cand_next;
    logic [1:0] mod3_reg;
    logic [1:0] mod3_next;
    logic       accept;

    assign item.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        limit_next     = limit_reg;
        next_cand_next = next_cand_reg;
        mod3_next      = mod3_reg;
        push.valid     = accept;
        push.entry.cand = next_cand_reg;
        push.entry.kind = KIND_TRIAL;
        if (cfg.valid)
        begin
            limit_next = cfg.limit;
        end
        priority if (item.restart)
        begin
            push.entry.kind = KIND_RESTART;
            push.entry.cand = '0;
            if (accept)
            begin
                next_cand_next = '0;
                mod3_next      = 2'd0;
            end
        end
        else if (next_cand_reg >= limit_reg)
        begin
            push.entry.kind = KIND_DONE;
            push.entry.cand = '0;
        end
        else
        begin
            if (accept)
            begin
                next_cand_next = next_cand_reg + value_t'(1);
                mod3_next      = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
            priority if (next_cand_reg < value_t'(2))
                push.entry.kind = KIND_COMPOSITE;
            else if (next_cand_reg == value_t'(2) || next_cand_reg == value_t'(3))
                push.entry.kind = KIND_PRIME;
            else if (!next_cand_reg[0] || mod3_reg == 2'd0)
                push.entry.kind = KIND_COMPOSITE;
            else
                push.entry.kind = KIND_TRIAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            next_cand_reg <= '0;
            mod3_reg      <= 2'd0;
        end
        else
        begin
            limit_reg     <= limit_next;
            next_cand_reg <= next_cand_next;
            mod3_reg      <= mod3_next;
        end
    end

endmodule

// ===== hw/rtl/pctd_queue.sv =====
// Short FIFO of classified work between the front and back ends.
`timescale 1ns / 1ps

module pctd_queue
    import pctd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qport_t push,
    output logic   full,
    output qport_t head,
    input  logic   pop
);

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            unique case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + (QPTR_W+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (QPTR_W+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/pctd_back.sv =====
// Back end: trial division with a bit-serial remainder unit, prime count, output register.
`timescale 1ns / 1ps

module pctd_back
    import pctd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  qport_t          head,
    output logic            pop,
    pctd_result_if.source   result
);

    back_state_t      state_reg, state_next;
    value_t           count_reg, count_next;
    value_t           v_reg, v_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    value_t           res_cand_reg, res_cand_next;
    logic             res_flag_reg, res_flag_next;
    value_t           res_total_reg, res_total_next;
    logic             res_done_reg, res_done_next;
    logic             out_valid_reg, out_valid_next;
    logic             load_out;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   trial_sub;

    assign trial     = {rem_reg, v_reg[bit_reg]};
    assign trial_sub = trial - {1'b0, d_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        v_next         = v_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        res_cand_next  = res_cand_reg;
        res_flag_next  = res_flag_reg;
        res_total_next = res_total_reg;
        res_done_next  = res_done_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop            = 1'b1;
                    res_cand_next  = head.entry.cand;
                    res_flag_next  = 1'b0;
                    res_total_next = count_reg;
                    res_done_next  = 1'b0;
                    state_next     = ST_EMIT;
                    unique case (head.entry.kind)
                        KIND_RESTART:
                        begin
                            count_next     = '0;
                            res_total_next = '0;
                        end
                        KIND_DONE:
                        begin
                            res_done_next = 1'b1;
                        end
                        KIND_COMPOSITE:
                        begin
                        end
                        KIND_PRIME:
                        begin
                            count_next     = count_reg + value_t'(1);
                            res_flag_next  = 1'b1;
                            res_total_next = count_reg + value_t'(1);
                        end
                        KIND_TRIAL:
                        begin
                            v_next     = head.entry.cand;
                            d_next     = DIV_W'(FIRST_DIV);
                            sq_next    = SQ_W'(FIRST_DIV * FIRST_DIV);
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > SQ_W'(v_reg))
                begin
                    count_next     = count_reg + value_t'(1);
                    res_flag_next  = 1'b1;
                    res_total_next = count_reg + value_t'(1);
                    state_next     = ST_EMIT;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BIT_W'(VALUE_WIDTH - 1);
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next = trial_sub[DIV_W] ? trial[DIV_W-1:0] : trial_sub[DIV_W-1:0];
                if (bit_reg == '0)
                begin
                    if (rem_next == '0)
                    begin
                        res_flag_next = 1'b0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        d_next     = d_reg + DIV_W'(2);
                        sq_next    = sq_reg + SQ_W'({d_reg, 2'b00}) + SQ_W'(4);
                        state_next = ST_CHECK;
                    end
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        res_cand_reg  <= res_cand_next;
        res_flag_reg  <= res_flag_next;
        res_total_reg <= res_total_next;
        res_done_reg  <= res_done_next;
        if (load_out)
        begin
            result.candidate   <= res_cand_reg;
            result.prime_flag  <= res_flag_reg;
            result.prime_total <= res_total_reg;
            result.done_res    <= res_done_reg;
        end
    end

    assign result.valid = out_valid_reg;

endmodule

// ===== hw/rtl/prime_counter_trial_division_core.sv =====
// Top level of the trial-division prime counter.
`timescale 1ns / 1ps

// Counts primes below a programmed limit, one candidate per item.
// Channels: item (restart bit), result (candidate, prime_flag, prime_total,
// done_res) and cfg (writes the limit; always ready, write only while idle).
// restart = 0 tests the next candidate or reports done_res once the limit is
// reached; restart = 1 clears candidate and count.
// The front end classifies an item in its accept cycle and queues it (4 deep).
// The back end answers restart, done, small, even and multiple-of-3 items
// without division: each is popped from the queue into the result registers,
// then loaded into the output register once it is free. Other candidates v
// are tried against each odd divisor d = 5, 7, ... with d*d <= v: one bound
// check, then the bit-serial remainder unit over the bits of v, which sets the rate.
// Results leave through an output register, so the back end keeps working
// while a result waits; when the receiver stalls, the queue fills and item
// ready drops. Reset clears limit, candidate, count and all valids.
module prime_counter_trial_division_core
    import pctd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pctd_item_if.sink     item,
    pctd_cfg_if.sink      cfg,
    pctd_result_if.source result
);

    qport_t push;
    qport_t head;
    logic   q_full;
    logic   pop;

    pctd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push)
    );

    pctd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    pctd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== hw/rtl/pctd_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module pctd_checker
    import pctd_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   out_valid,
    input logic   out_ready,
    input value_t out_candidate,
    input logic   out_prime_flag,
    input value_t out_prime_total,
    input logic   out_done_res
);

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_done_res |-> out_candidate == '0 && !out_prime_flag)
        else $error("done result carries a candidate");

    a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_prime_flag |-> out_prime_total != '0)
        else $error("prime reported with zero total");

    a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_prime_flag |->
            (out_candidate[0] || out_candidate == value_t'(2)) &&
            out_candidate >= value_t'(2))
        else $error("even or tiny candidate flagged prime");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_done_res && out_prime_flag |-> out_prime_total <= out_candidate)
        else $error("prime total exceeds candidate");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_candidate)
            && $stable(out_prime_total))
        else $error("stalled result changed");

endmodule

bind prime_counter_trial_division_core pctd_checker u_pctd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_candidate   (result.candidate),
    .out_prime_flag  (result.prime_flag),
    .out_prime_total (result.prime_total),
    .out_done_res    (result.done_res)
);
